[rtl/sha1md_pkg.sv]
// sha1md_pkg: shared types and constants for the SHA-1 digest engine.
// Used by sha1md_ctrl, sha1md_dp and sha1_message_digest. No dependencies.
package sha1md_pkg;

  localparam int WORD_W    = 32;
  localparam int FILL_W    = 6;      // 64-byte block
  localparam int ROUND_W   = 7;      // 0..79
  localparam int WIDX_W    = 3;      // digest word index 0..4
  localparam int NUM_WORDS = 5;
  localparam int WIN_WORDS = 16;
  localparam int CNT_W     = 64;

  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(79);
  localparam logic [WIDX_W-1:0]  LAST_WORD  = WIDX_W'(NUM_WORDS - 1);
  localparam logic [FILL_W-1:0]  FILL_LAST  = FILL_W'(63);
  localparam logic [FILL_W-1:0]  LEN_POS    = FILL_W'(56);

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [WORD_W-1:0] H0_INIT = 32'h67452301;
  localparam logic [WORD_W-1:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [WORD_W-1:0] H2_INIT = 32'h98BADCFE;
  localparam logic [WORD_W-1:0] H3_INIT = 32'h10325476;
  localparam logic [WORD_W-1:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BSEL_IN,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } bsel_t;

  typedef struct packed {
    logic               shift_en;   // shift one byte into the block window
    bsel_t              byte_sel;
    logic               count_en;   // message byte: bit count += 8
    logic               load_work;  // a..e <= chain
    logic               round_en;
    logic [ROUND_W-1:0] round_idx;
    logic               chain_add;
    logic               chain_init; // back to initial chain, clear counts
    logic [WIDX_W-1:0]  word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;    // fill level is 63
    logic fill_len_pos; // fill level is 56
  } dp_sts_t;

endpackage

[rtl/sha1_message_digest.sv]
// sha1_message_digest: one byte per input word; each 64-byte block is compressed once
// full (80 rounds in one shared round unit, then the chain add) while intake stalls.
// Padding feeds one byte a cycle outside compressions (one or two more compressions),
// then five digest words, one per cycle while out_stall is low.
// Synchronous active-low reset: initial chain, zero bit count and fill, idle.
// Depends on sha1md_pkg, sha1md_ctrl and sha1md_dp.
module sha1_message_digest (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_has_byte,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_message,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sha1md_pkg::WORD_W-1:0] out_digest_word,
  output logic [sha1md_pkg::WIDX_W-1:0] out_word_number,
  output logic                          out_last_word
);

  sha1md_pkg::dp_cmd_t cmd;
  sha1md_pkg::dp_sts_t sts;

  sha1md_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_word_number   (out_word_number),
    .out_last_word     (out_last_word),
    .sts               (sts),
    .cmd               (cmd)
  );

  sha1md_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_digest_word (out_digest_word)
  );

  // no intake while a digest is being delivered
  a_no_intake_on_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while digest pending");

  // digest words go out in order without gaps
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && (out_word_number == $past(out_word_number) + 3'd1))
    else $error("digest word sequence broken");

  // a compression start is always followed by rounds
  a_load_then_round: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_work |=> cmd.round_en && (cmd.round_idx == 7'd0))
    else $error("work load not followed by round 0");

  // the chain add only follows the last round
  a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.chain_add |-> $past(cmd.round_en) && ($past(cmd.round_idx) == 7'd79))
    else $error("chain add without completed rounds");

endmodule

[rtl/sha1md_ctrl.sv]
// sha1md_ctrl: sequencer for byte intake, padding, rounds and digest output.
// Depends on sha1md_pkg; drives sha1md_dp through dp_cmd_t.
module sha1md_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_has_byte,
  input  logic                          in_end_of_message,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sha1md_pkg::WIDX_W-1:0] out_word_number,
  output logic                          out_last_word,
  input  sha1md_pkg::dp_sts_t           sts,
  output sha1md_pkg::dp_cmd_t           cmd
);

  sha1md_pkg::state_t                   state_r, state_nxt;
  sha1md_pkg::state_t                   ret_r, ret_nxt;
  logic [sha1md_pkg::ROUND_W-1:0]       round_r, round_nxt;
  logic [sha1md_pkg::WIDX_W-1:0]        word_r, word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1md_pkg::ST_IDLE;
      ret_r   <= sha1md_pkg::ST_IDLE;
      round_r <= '0;
      word_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      round_r <= round_nxt;
      word_r  <= word_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    round_nxt = '0;
    word_nxt  = '0;
    unique case (state_r)
      sha1md_pkg::ST_IDLE: begin
        if (cmd.shift_en && sts.fill_last) begin
          state_nxt = sha1md_pkg::ST_ROUND;
          ret_nxt   = in_end_of_message ? sha1md_pkg::ST_PAD_MARK : sha1md_pkg::ST_IDLE;
        end else if (in_valid && in_end_of_message) begin
          state_nxt = sha1md_pkg::ST_PAD_MARK;
        end
      end
      sha1md_pkg::ST_PAD_MARK: begin
        if (sts.fill_last) begin
          state_nxt = sha1md_pkg::ST_ROUND;
          ret_nxt   = sha1md_pkg::ST_PAD_ZERO;
        end else begin
          state_nxt = sha1md_pkg::ST_PAD_ZERO;
        end
      end
      sha1md_pkg::ST_PAD_ZERO: begin
        if (sts.fill_len_pos) begin
          state_nxt = sha1md_pkg::ST_PAD_LEN;
        end else if (sts.fill_last) begin
          state_nxt = sha1md_pkg::ST_ROUND;
          ret_nxt   = sha1md_pkg::ST_PAD_ZERO;
        end
      end
      sha1md_pkg::ST_PAD_LEN: begin
        if (sts.fill_last) begin
          state_nxt = sha1md_pkg::ST_ROUND;
          ret_nxt   = sha1md_pkg::ST_OUT;
        end
      end
      sha1md_pkg::ST_ROUND: begin
        if (round_r == sha1md_pkg::LAST_ROUND) begin
          state_nxt = sha1md_pkg::ST_FINISH;
        end else begin
          round_nxt = round_r + 1'b1;
        end
      end
      sha1md_pkg::ST_FINISH: begin
        state_nxt = ret_r;
      end
      sha1md_pkg::ST_OUT: begin
        word_nxt = word_r;
        if (!out_stall) begin
          if (word_r == sha1md_pkg::LAST_WORD) begin
            state_nxt = sha1md_pkg::ST_IDLE;
            word_nxt  = '0;
          end else begin
            word_nxt = word_r + 1'b1;
          end
        end
      end
      default: state_nxt = sha1md_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd            = '0;
    cmd.byte_sel   = sha1md_pkg::BSEL_IN;
    cmd.round_idx  = round_r;
    cmd.word_idx   = word_r;
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    unique case (state_r)
      sha1md_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.shift_en  = in_valid && in_has_byte;
        cmd.count_en  = in_valid && in_has_byte;
        cmd.load_work = in_valid && in_has_byte && sts.fill_last;
      end
      sha1md_pkg::ST_PAD_MARK: begin
        cmd.shift_en  = 1'b1;
        cmd.byte_sel  = sha1md_pkg::BSEL_MARK;
        cmd.load_work = sts.fill_last;
      end
      sha1md_pkg::ST_PAD_ZERO: begin
        cmd.shift_en  = !sts.fill_len_pos;
        cmd.byte_sel  = sha1md_pkg::BSEL_ZERO;
        cmd.load_work = !sts.fill_len_pos && sts.fill_last;
      end
      sha1md_pkg::ST_PAD_LEN: begin
        cmd.shift_en  = 1'b1;
        cmd.byte_sel  = sha1md_pkg::BSEL_LEN;
        cmd.load_work = sts.fill_last;
      end
      sha1md_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      sha1md_pkg::ST_FINISH: begin
        cmd.chain_add = 1'b1;
      end
      sha1md_pkg::ST_OUT: begin
        out_valid      = 1'b1;
        cmd.chain_init = !out_stall && (word_r == sha1md_pkg::LAST_WORD);
      end
      default: ;
    endcase
  end

  assign out_word_number = word_r;
  assign out_last_word   = (word_r == sha1md_pkg::LAST_WORD);

endmodule

[rtl/sha1md_dp.sv]
// sha1md_dp: block window, message schedule, round registers, chain and bit count.
// Depends on sha1md_pkg; controlled by sha1md_ctrl through dp_cmd_t.
module sha1md_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    in_data_byte,
  input  sha1md_pkg::dp_cmd_t           cmd,
  output sha1md_pkg::dp_sts_t           sts,
  output logic [sha1md_pkg::WORD_W-1:0] out_digest_word
);

  localparam int W = sha1md_pkg::WORD_W;

  logic [W-1:0]                    win_r [sha1md_pkg::WIN_WORDS];
  logic [W-1:0]                    win_nxt [sha1md_pkg::WIN_WORDS];
  logic [W-1:0]                    chain_r [sha1md_pkg::NUM_WORDS];
  logic [W-1:0]                    a_r, b_r, c_r, d_r, e_r;
  logic [sha1md_pkg::FILL_W-1:0]   fill_r;
  logic [sha1md_pkg::CNT_W-1:0]    bitcnt_r;
  logic [7:0]                      byte_in;
  logic [sha1md_pkg::CNT_W-1:0]    len_shifted;
  logic [W-1:0]                    f_val, k_val, sched_new, tmp_val, wt;

  // length bytes go out most significant first, at fill levels 56..63
  assign len_shifted = bitcnt_r >> {~fill_r[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      sha1md_pkg::BSEL_IN:   byte_in = in_data_byte;
      sha1md_pkg::BSEL_MARK: byte_in = sha1md_pkg::PAD_MARK;
      sha1md_pkg::BSEL_ZERO: byte_in = 8'h00;
      default:               byte_in = len_shifted[7:0];
    endcase
  end

  // window word k holds w[t+k] during round t
  assign wt        = win_r[0];
  assign sched_new = {win_r[13][W-2:0] ^ win_r[8][W-2:0] ^ win_r[2][W-2:0] ^ win_r[0][W-2:0],
                      win_r[13][W-1] ^ win_r[8][W-1] ^ win_r[2][W-1] ^ win_r[0][W-1]};

  always_comb begin
    for (int j = 0; j < sha1md_pkg::WIN_WORDS; j++) begin
      win_nxt[j] = win_r[j];
    end
    if (cmd.shift_en) begin
      for (int j = 0; j < sha1md_pkg::WIN_WORDS - 1; j++) begin
        win_nxt[j] = {win_r[j][W-9:0], win_r[j+1][W-1:W-8]};
      end
      win_nxt[sha1md_pkg::WIN_WORDS-1] = {win_r[sha1md_pkg::WIN_WORDS-1][W-9:0], byte_in};
    end else if (cmd.round_en) begin
      for (int j = 0; j < sha1md_pkg::WIN_WORDS - 1; j++) begin
        win_nxt[j] = win_r[j+1];
      end
      win_nxt[sha1md_pkg::WIN_WORDS-1] = sched_new;
    end
  end

  always_comb begin
    if (cmd.round_idx < sha1md_pkg::ROUND_W'(20)) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = sha1md_pkg::K0;
    end else if (cmd.round_idx < sha1md_pkg::ROUND_W'(40)) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1md_pkg::K1;
    end else if (cmd.round_idx < sha1md_pkg::ROUND_W'(60)) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = sha1md_pkg::K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1md_pkg::K3;
    end
  end

  assign tmp_val = {a_r[W-6:0], a_r[W-1:W-5]} + f_val + e_r + k_val + wt;

  always_ff @(posedge clk) begin
    for (int j = 0; j < sha1md_pkg::WIN_WORDS; j++) begin
      win_r[j] <= win_nxt[j];
    end
    if (cmd.load_work) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round_en) begin
      a_r <= tmp_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[W-1:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.chain_init) begin
      chain_r[0] <= sha1md_pkg::H0_INIT;
      chain_r[1] <= sha1md_pkg::H1_INIT;
      chain_r[2] <= sha1md_pkg::H2_INIT;
      chain_r[3] <= sha1md_pkg::H3_INIT;
      chain_r[4] <= sha1md_pkg::H4_INIT;
      fill_r     <= '0;
      bitcnt_r   <= '0;
    end else begin
      if (cmd.chain_add) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (cmd.shift_en) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.count_en) begin
        bitcnt_r <= bitcnt_r + sha1md_pkg::CNT_W'(8);
      end
    end
  end

  always_comb begin
    case (cmd.word_idx)
      3'd0:    out_digest_word = chain_r[0];
      3'd1:    out_digest_word = chain_r[1];
      3'd2:    out_digest_word = chain_r[2];
      3'd3:    out_digest_word = chain_r[3];
      default: out_digest_word = chain_r[4];
    endcase
  end

  assign sts.fill_last    = (fill_r == sha1md_pkg::FILL_LAST);
  assign sts.fill_len_pos = (fill_r == sha1md_pkg::LEN_POS);

endmodule
